[rtl/pt2d_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package pt2d_pkg;

  localparam int DATA_W            = 32;
  localparam int CORDIC_STAGES_DEF = 24;
  localparam int FRAC_BITS_DEF     = 16;

  // Guard bits kept below the coordinate LSB inside the CORDIC datapath.
  localparam int GUARD_BITS = 16;
  // CORDIC coordinate width: the gain-corrected point grows to just under 2^48.
  localparam int CW = 50;
  // Residual angle width, one bit above the binary angle.
  localparam int ZW = 33;

  // Inverse CORDIC gain as an unsigned fraction of 2^32.
  localparam logic [31:0] GAIN_K = 32'h9B74_EDA8;

  // Degree reduction: quotient estimate is a * RECIP >> RECIP_SHIFT.
  localparam int RECIP_SHIFT = 48;
  localparam int QW          = 2 * DATA_W + 1 - RECIP_SHIFT;

  // 2^32 = 360 * TURN_Q + TURN_REM, used to split the degree-to-turn division.
  localparam logic [23:0] TURN_Q   = 24'd11930464;
  localparam int          TURN_REM = 256;
  localparam logic [7:0]  BAM_RND  = 8'd180;

  // Exact floor(m / 45) for any 30-bit m.
  localparam logic [30:0] DIV45_MAGIC = 31'd1527099484;
  localparam int          DIV45_SHIFT = 36;

  // A quarter turn as a binary angle.
  localparam logic signed [31:0] QUARTER = 32'sh4000_0000;

  typedef enum logic [2:0] {
    OP_ROTATE    = 3'd0,
    OP_TRANSLATE = 3'd1,
    OP_SCALE     = 3'd2,
    OP_REFLECT_X = 3'd3,
    OP_REFLECT_Y = 3'd4
  } op_t;

  typedef struct packed {
    logic                     ov;
    logic signed [DATA_W-1:0] v;
  } sat_t;

  // Work that rides beside the rotation datapath: the finished result of the
  // non-rotating operations and which of the two the output takes.
  typedef struct packed {
    logic                     rot;
    logic signed [DATA_W-1:0] ox;
    logic signed [DATA_W-1:0] oy;
    logic                     ov;
  } side_t;

  function automatic logic signed [63:0] sx64(input logic signed [DATA_W-1:0] v);
    return {{(64 - DATA_W){v[DATA_W-1]}}, v};
  endfunction

  function automatic sat_t sat32(input logic signed [63:0] v);
    sat_t r;
    if (v > 64'sh7FFF_FFFF) begin
      r.ov = 1'b1;
      r.v  = 32'sh7FFF_FFFF;
    end else if (v < -64'sh8000_0000) begin
      r.ov = 1'b1;
      r.v  = 32'sh8000_0000;
    end else begin
      r.ov = 1'b0;
      r.v  = v[DATA_W-1:0];
    end
    return r;
  endfunction

  // atan(2^-i) as a binary angle, one full turn = 2^32.
  function automatic logic [31:0] atan_bam(input logic [4:0] idx);
    logic [31:0] r;
    case (idx)
      5'd0:  r = 32'h2000_0000;
      5'd1:  r = 32'h12E4_051E;
      5'd2:  r = 32'h09FB_385B;
      5'd3:  r = 32'h0511_11D4;
      5'd4:  r = 32'h028B_0D43;
      5'd5:  r = 32'h0145_D7E1;
      5'd6:  r = 32'h00A2_F61E;
      5'd7:  r = 32'h0051_7C55;
      5'd8:  r = 32'h0028_BE53;
      5'd9:  r = 32'h0014_5F2F;
      5'd10: r = 32'h000A_2F98;
      5'd11: r = 32'h0005_17CC;
      5'd12: r = 32'h0002_8BE6;
      5'd13: r = 32'h0001_45F3;
      5'd14: r = 32'h0000_A2FA;
      5'd15: r = 32'h0000_517D;
      5'd16: r = 32'h0000_28BE;
      5'd17: r = 32'h0000_145F;
      5'd18: r = 32'h0000_0A30;
      5'd19: r = 32'h0000_0518;
      5'd20: r = 32'h0000_028C;
      5'd21: r = 32'h0000_0146;
      5'd22: r = 32'h0000_00A3;
      5'd23: r = 32'h0000_0051;
      5'd24: r = 32'h0000_0029;
      5'd25: r = 32'h0000_0014;
      5'd26: r = 32'h0000_000A;
      5'd27: r = 32'h0000_0005;
      5'd28: r = 32'h0000_0003;
      5'd29: r = 32'h0000_0001;
      5'd30: r = 32'h0000_0001;
      5'd31: r = 32'h0000_0000;
      default: r = 32'h0000_0000;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/point_transform_2d.sv]
`timescale 1ns / 1ps
`default_nettype none
// 2-D point transform pipeline.
// Input channel: in_valid / in_stall carry one word of operation, point
// (x_in, y_in) and arguments arg_a, arg_b, all signed fixed point with
// FRAC_BITS fraction bits. Operations: rotate by arg_a degrees, translate by
// (arg_a, arg_b), scale by (arg_a, arg_b), reflect across the x or y axis.
// Output channel: out_valid / out_stall carry one word per input word, in
// order: x_out, y_out saturated to 32 bits and overflow set when either was.
// The word passes eight stages of input capture, angle reduction, prescaling
// and quadrant folding, one stage per CORDIC iteration and the output
// register, and the first of these loads at the accepting edge itself.
// A new word is taken every cycle while the pipeline is not held.
// The whole pipeline moves as one; it holds only while the output register
// has a word and out_stall is high, and in_stall then follows out_stall in
// the same cycle. Empty slots hold along with the words, so bubbles are not
// squeezed out behind a stalled output.
// Synchronous reset clears every valid bit; no word survives it.
module point_transform_2d #(
  parameter int CORDIC_STAGES = pt2d_pkg::CORDIC_STAGES_DEF,
  parameter int FRAC_BITS     = pt2d_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [2:0]                        operation,
  input  logic signed [pt2d_pkg::DATA_W-1:0] x_in,
  input  logic signed [pt2d_pkg::DATA_W-1:0] y_in,
  input  logic signed [pt2d_pkg::DATA_W-1:0] arg_a,
  input  logic signed [pt2d_pkg::DATA_W-1:0] arg_b,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [pt2d_pkg::DATA_W-1:0] x_out,
  output logic signed [pt2d_pkg::DATA_W-1:0] y_out,
  output logic                              overflow
);
  import pt2d_pkg::*;

  localparam int PW = FRAC_BITS + 9;
  localparam logic [PW-1:0] PERIOD = PW'(64'd360 << FRAC_BITS);
  localparam logic [31:0] RECIP = 32'((64'd1 << RECIP_SHIFT) / (64'd360 << FRAC_BITS));
  localparam logic signed [63:0] SCALE_RND = 64'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [63:0] GUARD_RND = 64'sd1 <<< (GUARD_BITS - 1);
  localparam int NV = CORDIC_STAGES + 9;

  logic          adv;
  logic [NV-1:0] vpipe;

  assign adv       = !(out_valid && out_stall);
  assign in_stall  = !adv;
  assign out_valid = vpipe[NV-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else if (adv) begin
      vpipe <= {vpipe[NV-2:0], in_valid};
    end
  end

  // Stage 1: input register.
  logic [2:0]               op1;
  logic signed [DATA_W-1:0] x1, y1, a1, b1;

  always_ff @(posedge clk) begin
    if (adv) begin
      op1 <= operation;
      x1  <= x_in;
      y1  <= y_in;
      a1  <= arg_a;
      b1  <= arg_b;
    end
  end

  // Stage 2: quotient estimate of the angle by one turn, scale products.
  logic signed [2*DATA_W:0] prod_q;
  logic signed [63:0]       sxp, syp;
  logic [2:0]               op2;
  logic signed [DATA_W-1:0] x2, y2, a2, b2;
  logic signed [QW-1:0]     q2;
  logic signed [63:0]       sxp2, syp2;

  assign prod_q = a1 * $signed({1'b0, RECIP});
  assign sxp    = x1 * a1;
  assign syp    = y1 * b1;

  always_ff @(posedge clk) begin
    if (adv) begin
      op2  <= op1;
      x2   <= x1;
      y2   <= y1;
      a2   <= a1;
      b2   <= b1;
      q2   <= prod_q[2*DATA_W:RECIP_SHIFT];
      sxp2 <= sxp;
      syp2 <= syp;
    end
  end

  // Stage 3: first remainder; the non-rotating operations finish here.
  logic signed [63:0]   qp, r0_full, wide_x, wide_y;
  sat_t                 sat_x, sat_y;
  logic signed [PW+1:0] r03;
  side_t                side3;
  logic signed [DATA_W-1:0] x3, y3;

  assign qp      = q2 * $signed({1'b0, PERIOD});
  assign r0_full = sx64(a2) - qp;

  always_comb begin
    wide_x = sx64(x2);
    wide_y = sx64(y2);
    case (op2)
      OP_TRANSLATE: begin
        wide_x = sx64(x2) + sx64(a2);
        wide_y = sx64(y2) + sx64(b2);
      end
      OP_SCALE: begin
        wide_x = (sxp2 + SCALE_RND) >>> FRAC_BITS;
        wide_y = (syp2 + SCALE_RND) >>> FRAC_BITS;
      end
      OP_REFLECT_X: begin
        wide_y = -sx64(y2);
      end
      OP_REFLECT_Y: begin
        wide_x = -sx64(x2);
      end
      default: begin
        wide_x = sx64(x2);
        wide_y = sx64(y2);
      end
    endcase
  end

  assign sat_x = sat32(wide_x);
  assign sat_y = sat32(wide_y);

  always_ff @(posedge clk) begin
    if (adv) begin
      r03       <= r0_full[PW+1:0];
      side3.rot <= (op2 == OP_ROTATE);
      side3.ox  <= sat_x.v;
      side3.oy  <= sat_y.v;
      side3.ov  <= sat_x.ov | sat_y.ov;
      x3        <= x2;
      y3        <= y2;
    end
  end

  // Stage 4: the estimate is off by at most one turn; fix it.
  logic signed [PW+1:0] r_fix;
  logic [PW-1:0]        r4;
  side_t                side4;
  logic signed [DATA_W-1:0] x4, y4;

  always_comb begin
    if (r03 < 0) begin
      r_fix = r03 + $signed({2'b00, PERIOD});
    end else if (r03 >= $signed({2'b00, PERIOD})) begin
      r_fix = r03 - $signed({2'b00, PERIOD});
    end else begin
      r_fix = r03;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r4    <= r_fix[PW-1:0];
      side4 <= side3;
      x4    <= x3;
      y4    <= y3;
    end
  end

  // Stage 5: degrees to binary angle. With r = hi * 2^F + lo the rounded
  // quotient is hi * TURN_Q + floor((hi * TURN_REM + lo * 2^(32-F) + 180) / 360).
  logic [8:0]           hi;
  logic [FRAC_BITS-1:0] lo;
  logic [32:0]          hiq, m_full;
  logic [32:0]          hiq5;
  logic [29:0]          m35;
  side_t                side5;
  logic signed [DATA_W-1:0] x5, y5;

  assign hi     = r4[PW-1:FRAC_BITS];
  assign lo     = r4[FRAC_BITS-1:0];
  assign hiq    = 33'(hi) * 33'(TURN_Q);
  assign m_full = 33'(hi) * 33'(TURN_REM) + (33'(lo) << (32 - FRAC_BITS)) + 33'(BAM_RND);

  always_ff @(posedge clk) begin
    if (adv) begin
      hiq5  <= hiq;
      m35   <= m_full[32:3];
      side5 <= side4;
      x5    <= x4;
      y5    <= y4;
    end
  end

  // Stage 6: divide by 45 through the reciprocal; gain-correct the point.
  logic [60:0]        q45p;
  logic signed [63:0] px, py;
  logic [32:0]        hiq6;
  logic [24:0]        q456;
  logic signed [63:0] px6, py6;
  side_t              side6;

  assign q45p = 61'(m35) * 61'(DIV45_MAGIC);
  assign px   = x5 * $signed({1'b0, GAIN_K});
  assign py   = y5 * $signed({1'b0, GAIN_K});

  always_ff @(posedge clk) begin
    if (adv) begin
      hiq6  <= hiq5;
      q456  <= q45p[60:DIV45_SHIFT];
      px6   <= px;
      py6   <= py;
      side6 <= side5;
    end
  end

  // Stage 7: binary angle complete; round the point to the guard precision.
  logic [32:0]        bam_sum;
  logic signed [63:0] pxr, pyr;
  logic [31:0]        bam7;
  logic signed [CW-1:0] cx7, cy7;
  side_t              side7;

  assign bam_sum = hiq6 + 33'(q456);
  assign pxr     = (px6 + GUARD_RND) >>> GUARD_BITS;
  assign pyr     = (py6 + GUARD_RND) >>> GUARD_BITS;

  always_ff @(posedge clk) begin
    if (adv) begin
      bam7  <= bam_sum[31:0];
      cx7   <= pxr[CW-1:0];
      cy7   <= pyr[CW-1:0];
      side7 <= side6;
    end
  end

  // Stage 8: angles beyond a quarter turn either way are turned by half a
  // turn, which negates the point.
  logic signed [31:0]   ang7;
  logic                 far7;
  logic signed [CW-1:0] cxs [0:CORDIC_STAGES];
  logic signed [CW-1:0] cys [0:CORDIC_STAGES];
  logic signed [ZW-1:0] zs  [0:CORDIC_STAGES-1];
  side_t                sides [0:CORDIC_STAGES];

  assign ang7 = $signed(bam7);
  assign far7 = (ang7 > QUARTER) || (ang7 < -QUARTER);

  always_ff @(posedge clk) begin
    if (adv) begin
      cxs[0]   <= far7 ? -cx7 : cx7;
      cys[0]   <= far7 ? -cy7 : cy7;
      zs[0]    <= {bam7[31] ^ far7, bam7[31] ^ far7, bam7[30:0]};
      sides[0] <= side7;
    end
  end

  // CORDIC iterations, one register stage each.
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    localparam logic [ZW-1:0] ATAN_STEP = ZW'(atan_bam(5'(i)));
    logic signed [CW-1:0] dx, dy;

    assign dx = cys[i] >>> i;
    assign dy = cxs[i] >>> i;

    always_ff @(posedge clk) begin
      if (adv) begin
        if (!zs[i][ZW-1]) begin
          cxs[i+1] <= cxs[i] - dx;
          cys[i+1] <= cys[i] + dy;
        end else begin
          cxs[i+1] <= cxs[i] + dx;
          cys[i+1] <= cys[i] - dy;
        end
        sides[i+1] <= sides[i];
      end
    end

    // The last iteration leaves no angle for anyone to use.
    if (i < CORDIC_STAGES - 1) begin : g_angle
      always_ff @(posedge clk) begin
        if (adv) begin
          if (!zs[i][ZW-1]) begin
            zs[i+1] <= zs[i] - ATAN_STEP;
          end else begin
            zs[i+1] <= zs[i] + ATAN_STEP;
          end
        end
      end
    end
  end

  // Output register: drop the guard bits, saturate, pick the result.
  logic signed [63:0] ext_x, ext_y, fin_x, fin_y;
  sat_t               rot_x, rot_y;
  side_t              side_n;

  assign side_n = sides[CORDIC_STAGES];
  assign ext_x  = $signed({{(64 - CW){cxs[CORDIC_STAGES][CW-1]}}, cxs[CORDIC_STAGES]});
  assign ext_y  = $signed({{(64 - CW){cys[CORDIC_STAGES][CW-1]}}, cys[CORDIC_STAGES]});
  assign fin_x  = (ext_x + GUARD_RND) >>> GUARD_BITS;
  assign fin_y  = (ext_y + GUARD_RND) >>> GUARD_BITS;
  assign rot_x  = sat32(fin_x);
  assign rot_y  = sat32(fin_y);

  always_ff @(posedge clk) begin
    if (adv) begin
      if (side_n.rot) begin
        x_out    <= rot_x.v;
        y_out    <= rot_y.v;
        overflow <= rot_x.ov | rot_y.ov;
      end else begin
        x_out    <= side_n.ox;
        y_out    <= side_n.oy;
        overflow <= side_n.ov;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/pt2d_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module pt2d_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] x_out,
  input logic [31:0] y_out,
  input logic        overflow
);

  // The pipeline moves as one, so the input holds exactly when the output does.
  a_stall_link: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("in_stall does not follow the held output word");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output word dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(x_out) && $stable(y_out) && $stable(overflow))
    else $error("output word changed while stalled");

  // A raised flag always comes with at least one coordinate at a rail.
  a_ovf_rail: assert property (@(posedge clk) disable iff (rst)
    out_valid && overflow |->
      (x_out == 32'h7FFF_FFFF || x_out == 32'h8000_0000 ||
       y_out == 32'h7FFF_FFFF || y_out == 32'h8000_0000))
    else $error("overflow set without a saturated coordinate");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output word present right after reset");

endmodule

bind point_transform_2d pt2d_checker u_pt2d_checker (.*);

`default_nettype wire
